@@ rtl/core/assert_macros.svh @@
// assertion helpers, clocked on i_clk, off while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);

`endif

@@ rtl/core/pmq_pkg.sv @@
// ----------------------------------------------------------------------------
// pmq_pkg
// types, codes and defaults of the priority message queue block
// ----------------------------------------------------------------------------
package pmq_pkg;

    localparam int PMQ_ENDPOINTS = 128;
    localparam int PMQ_SLOTS     = 256;

    localparam logic [15:0] MAX_LEN_RESET = 16'd4096;

    localparam logic [1:0] REQ_CREATE  = 2'd0;
    localparam logic [1:0] REQ_DESTROY = 2'd1;
    localparam logic [1:0] REQ_SEND    = 2'd2;
    localparam logic [1:0] REQ_RECV    = 2'd3;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_INVALID     = 3'd1;
    localparam logic [2:0] ST_NO_MEMORY   = 3'd2;
    localparam logic [2:0] ST_WOULD_BLOCK = 3'd3;
    localparam logic [2:0] ST_NO_ENDPOINT = 3'd4;

    localparam logic REG_MAX_LEN = 1'b0;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  endpoint_id;
        logic [31:0] payload_handle;
        logic [15:0] payload_length;
        logic [7:0]  msg_priority;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  new_endpoint_id;
        logic [31:0] out_handle;
        logic [15:0] out_length;
        logic [7:0]  out_priority;
    } t_rsp;

endpackage

@@ rtl/core/priority_message_queues_unit.sv @@
// ----------------------------------------------------------------------------
// priority_message_queues_unit
// endpoint table with priority ordered message queues over a shared slot pool
// ----------------------------------------------------------------------------
// A request beat is taken when start is high and busy is low. i_req carries
// the request type, endpoint id and, for send, the message fields. Exactly
// one result beat follows: o_done is high for one cycle with o_result valid;
// the receiver cannot stall and must take it in that cycle.
// Create takes the lowest closed endpoint; send does a sorted insert that walks
// the queue one linked list step at a time through the slot rams and links the
// new slot ahead of the first entry of lower priority, or at the tail.
// busy stays high until the result beat; a new request may be given in the
// cycle of o_done. The user must write max_length over the apb port only while
// idle; the block itself does not enforce it. Reset closes all endpoints,
// empties the slot pool and sets max_length to 4096; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module priority_message_queues_unit import pmq_pkg::*; #(
    parameter int ENDPOINTS = PMQ_ENDPOINTS,
    parameter int SLOTS     = PMQ_SLOTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  t_req        i_req,
    output logic        busy,
    output logic        o_done,
    output t_rsp        o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int EW  = $clog2(ENDPOINTS);
    localparam int SIW = $clog2(SLOTS);
    localparam int SW  = SIW + 1;
    localparam int QW  = 2 * SIW;
    localparam logic [SW-1:0] NULL_SLOT = SW'(SLOTS);
    localparam logic [EW-1:0] LAST_EP   = EW'(ENDPOINTS - 1);
    localparam logic [8:0]    EP_COUNT  = 9'(ENDPOINTS);

    typedef struct packed {
        logic [31:0] handle;
        logic [15:0] length;
        logic [7:0]  prio;
    } t_slot;

    typedef enum logic [4:0] {
        S_IDLE, S_QW, S_DEC, S_SCAN, S_DFREE, S_TAKE_W, S_TAKE, S_STORE,
        S_HP_W, S_HP, S_WALK, S_NX_W, S_NX, S_NP_W, S_NP, S_LINK, S_RX_W, S_RX
    } t_state;

    t_state                r_state;
    t_req                  r_req;
    t_rsp                  r_rsp;
    logic                  r_done;
    logic [EW-1:0]         r_eidx;
    logic                  r_idok;
    logic [ENDPOINTS-1:0]  r_open;
    logic [ENDPOINTS-1:0]  r_nonempty;
    logic [SW-1:0]         r_free_head;
    logic [SW-1:0]         r_fresh;
    logic [SIW-1:0]        r_slot;
    logic [SIW-1:0]        r_cur;
    logic [SW-1:0]         r_nx;
    logic [EW-1:0]         r_cnt;
    logic [15:0]           r_max_len;

    logic                  r_q_we;
    logic [QW-1:0]         r_q_wd;
    logic                  r_n_we;
    logic [SIW-1:0]        r_n_wa;
    logic [SW-1:0]         r_n_wd;
    logic [SIW-1:0]        r_n_ra;
    logic                  r_d_we;
    logic [SIW-1:0]        r_d_ra;

    logic [QW-1:0]         q_rdata;
    logic [SW-1:0]         n_rdata;
    t_slot                 d_rdata;
    t_slot                 d_wdata;
    logic [SIW-1:0]        q_head;
    logic [SIW-1:0]        q_tail;
    logic [7:0]            id_m1;
    logic                  id_ok;
    logic                  accept;
    logic                  cfg_wr;

    assign q_head  = q_rdata[QW-1:SIW];
    assign q_tail  = q_rdata[SIW-1:0];
    assign id_m1   = i_req.endpoint_id - 8'd1;
    assign id_ok   = (i_req.endpoint_id != 8'd0) && ({1'b0, i_req.endpoint_id} <= EP_COUNT);
    assign accept  = start && !busy;
    assign busy    = (r_state != S_IDLE);
    assign o_done  = r_done;
    assign o_result = r_rsp;
    assign d_wdata = '{handle: r_req.payload_handle, length: r_req.payload_length,
                       prio: r_req.msg_priority};

    // queue head and tail per endpoint
    pmq_ram #(.WIDTH(QW), .DEPTH(ENDPOINTS)) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (r_q_we),
        .i_waddr (r_eidx),
        .i_wdata (r_q_wd),
        .i_raddr (r_eidx),
        .o_rdata (q_rdata)
    );

    // slot links
    pmq_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (r_n_we),
        .i_waddr (r_n_wa),
        .i_wdata (r_n_wd),
        .i_raddr (r_n_ra),
        .o_rdata (n_rdata)
    );

    // slot message data
    pmq_ram #(.WIDTH($bits(t_slot)), .DEPTH(SLOTS)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (r_d_we),
        .i_waddr (r_slot),
        .i_wdata (d_wdata),
        .i_raddr (r_d_ra),
        .o_rdata (d_rdata)
    );

    // config register
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAX_LEN) ? {16'd0, r_max_len} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (cfg_wr && paddr[2] == REG_MAX_LEN) begin
            r_max_len <= pwdata[15:0];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_done      <= 1'b0;
            r_open      <= '0;
            r_nonempty  <= '0;
            r_free_head <= NULL_SLOT;
            r_fresh     <= '0;
            r_q_we      <= 1'b0;
            r_n_we      <= 1'b0;
            r_d_we      <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_q_we <= 1'b0;
            r_n_we <= 1'b0;
            r_d_we <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_req   <= i_req;
                        r_eidx  <= id_m1[EW-1:0];
                        r_idok  <= id_ok;
                        r_rsp   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_QW;
                    end
                end
                S_QW: begin
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    case (r_req.req_type)
                        REQ_CREATE: begin
                            r_state <= S_SCAN;
                        end
                        REQ_DESTROY: begin
                            if (!r_idok || !r_open[r_eidx]) begin
                                r_rsp.status <= ST_INVALID;
                                r_done       <= 1'b1;
                                r_state      <= S_IDLE;
                            end else if (r_nonempty[r_eidx]) begin
                                r_state <= S_DFREE;
                            end else begin
                                r_open[r_eidx] <= 1'b0;
                                r_rsp.status   <= ST_OK;
                                r_done         <= 1'b1;
                                r_state        <= S_IDLE;
                            end
                        end
                        REQ_SEND: begin
                            if (r_req.payload_handle == 32'd0
                                || r_req.payload_length > r_max_len
                                || !r_idok || !r_open[r_eidx]) begin
                                r_rsp.status <= ST_INVALID;
                                r_done       <= 1'b1;
                                r_state      <= S_IDLE;
                            end else if (r_free_head < NULL_SLOT) begin
                                r_slot  <= r_free_head[SIW-1:0];
                                r_n_ra  <= r_free_head[SIW-1:0];
                                r_state <= S_TAKE_W;
                            end else if (r_fresh < NULL_SLOT) begin
                                r_slot  <= r_fresh[SIW-1:0];
                                r_fresh <= r_fresh + SW'(1);
                                r_state <= S_STORE;
                            end else begin
                                r_rsp.status <= ST_NO_MEMORY;
                                r_done       <= 1'b1;
                                r_state      <= S_IDLE;
                            end
                        end
                        default: begin
                            if (!r_idok || !r_open[r_eidx] || !r_nonempty[r_eidx]) begin
                                r_rsp.status <= ST_WOULD_BLOCK;
                                r_done       <= 1'b1;
                                r_state      <= S_IDLE;
                            end else begin
                                r_d_ra  <= q_head;
                                r_n_ra  <= q_head;
                                r_state <= S_RX_W;
                            end
                        end
                    endcase
                end
                S_SCAN: begin
                    if (!r_open[r_cnt]) begin
                        r_open[r_cnt]          <= 1'b1;
                        r_nonempty[r_cnt]      <= 1'b0;
                        r_rsp.status           <= ST_OK;
                        r_rsp.new_endpoint_id  <= 8'(r_cnt + 9'd1);
                        r_done                 <= 1'b1;
                        r_state                <= S_IDLE;
                    end else if (r_cnt == LAST_EP) begin
                        r_rsp.status <= ST_NO_ENDPOINT;
                        r_done       <= 1'b1;
                        r_state      <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + EW'(1);
                    end
                end
                S_DFREE: begin
                    r_n_we             <= 1'b1;
                    r_n_wa             <= q_tail;
                    r_n_wd             <= r_free_head;
                    r_free_head        <= {1'b0, q_head};
                    r_open[r_eidx]     <= 1'b0;
                    r_nonempty[r_eidx] <= 1'b0;
                    r_rsp.status       <= ST_OK;
                    r_done             <= 1'b1;
                    r_state            <= S_IDLE;
                end
                S_TAKE_W: begin
                    r_state <= S_TAKE;
                end
                S_TAKE: begin
                    r_free_head <= (n_rdata > NULL_SLOT) ? NULL_SLOT : n_rdata;
                    r_state     <= S_STORE;
                end
                S_STORE: begin
                    r_d_we <= 1'b1;
                    if (!r_nonempty[r_eidx]) begin
                        r_n_we             <= 1'b1;
                        r_n_wa             <= r_slot;
                        r_n_wd             <= NULL_SLOT;
                        r_q_we             <= 1'b1;
                        r_q_wd             <= {r_slot, r_slot};
                        r_nonempty[r_eidx] <= 1'b1;
                        r_rsp.status       <= ST_OK;
                        r_done             <= 1'b1;
                        r_state            <= S_IDLE;
                    end else begin
                        r_d_ra  <= q_head;
                        r_state <= S_HP_W;
                    end
                end
                S_HP_W: begin
                    r_state <= S_HP;
                end
                S_HP: begin
                    if (r_req.msg_priority > d_rdata.prio) begin
                        r_n_we       <= 1'b1;
                        r_n_wa       <= r_slot;
                        r_n_wd       <= {1'b0, q_head};
                        r_q_we       <= 1'b1;
                        r_q_wd       <= {r_slot, q_tail};
                        r_rsp.status <= ST_OK;
                        r_done       <= 1'b1;
                        r_state      <= S_IDLE;
                    end else begin
                        r_cur   <= q_head;
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (r_cur == q_tail) begin
                        r_n_we  <= 1'b1;
                        r_n_wa  <= r_slot;
                        r_n_wd  <= NULL_SLOT;
                        r_q_we  <= 1'b1;
                        r_q_wd  <= {q_head, r_slot};
                        r_state <= S_LINK;
                    end else begin
                        r_n_ra  <= r_cur;
                        r_state <= S_NX_W;
                    end
                end
                S_NX_W: begin
                    r_state <= S_NX;
                end
                S_NX: begin
                    r_nx    <= n_rdata;
                    r_d_ra  <= n_rdata[SIW-1:0];
                    r_state <= S_NP_W;
                end
                S_NP_W: begin
                    r_state <= S_NP;
                end
                S_NP: begin
                    if (d_rdata.prio < r_req.msg_priority) begin
                        r_n_we  <= 1'b1;
                        r_n_wa  <= r_slot;
                        r_n_wd  <= r_nx;
                        r_state <= S_LINK;
                    end else begin
                        r_cur   <= r_nx[SIW-1:0];
                        r_state <= S_WALK;
                    end
                end
                S_LINK: begin
                    r_n_we       <= 1'b1;
                    r_n_wa       <= r_cur;
                    r_n_wd       <= {1'b0, r_slot};
                    r_rsp.status <= ST_OK;
                    r_done       <= 1'b1;
                    r_state      <= S_IDLE;
                end
                S_RX_W: begin
                    r_state <= S_RX;
                end
                S_RX: begin
                    r_rsp.status       <= ST_OK;
                    r_rsp.out_handle   <= d_rdata.handle;
                    r_rsp.out_length   <= d_rdata.length;
                    r_rsp.out_priority <= d_rdata.prio;
                    if (q_head == q_tail) begin
                        r_nonempty[r_eidx] <= 1'b0;
                    end else begin
                        r_q_we <= 1'b1;
                        r_q_wd <= {n_rdata[SIW-1:0], q_tail};
                    end
                    r_n_we      <= 1'b1;
                    r_n_wa      <= q_head;
                    r_n_wd      <= r_free_head;
                    r_free_head <= {1'b0, q_head};
                    r_done      <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `ASSERT_PROP(a_done_after_busy, o_done |-> $past(busy), "result beat without a request")
    `ASSERT_PROP(a_accept_busy, (start && !busy) |=> (busy && !o_done), "request not taken up")
    `ASSERT_NEVER(a_free_head_range, r_free_head > NULL_SLOT, "free list head out of range")
    `ASSERT_NEVER(a_fresh_range, r_fresh > NULL_SLOT, "fresh slot count out of range")

endmodule

@@ rtl/core/pmq_ram.sv @@
// ----------------------------------------------------------------------------
// pmq_ram
// single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module pmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
